@@ rtl/mwg_pkg.sv @@
`default_nettype none

package mwg_pkg;

	localparam int PeriodRegW = 11;
	localparam int ModeW = 2;
	localparam int SampleW = 8;

	localparam logic [ModeW-1:0] ModeSine = 2'd0;
	localparam logic [ModeW-1:0] ModeSquare = 2'd1;
	localparam logic [ModeW-1:0] ModeTriangle = 2'd2;
	localparam logic [ModeW-1:0] ModeSaw = 2'd3;

	localparam logic RegWaveMode = 1'b0;
	localparam logic RegPeriod = 1'b1;

	typedef logic [1:0] op_t;
	localparam op_t OpDirect = 2'd0;
	localparam op_t OpSine = 2'd1;
	localparam op_t OpLinear = 2'd2;

	typedef struct packed {
		op_t kind;
		logic period_end;
		logic [SampleW-1:0] direct;
	} mwg_ctrl_t;

	localparam int SineSteps = 1024;
	localparam int QuotW = $clog2(SineSteps);
	localparam int HalfSteps = SineSteps / 2;
	localparam int QuarterSteps = SineSteps / 4;
	localparam int FoldW = QuotW - 1;
	localparam int LutIdxW = $clog2(QuarterSteps);

	localparam logic [SampleW-1:0] MidCode = 8'd127;
	localparam logic [SampleW-1:0] PeakCode = 8'd254;
	localparam logic [SampleW-1:0] FullCode = 8'd255;

	localparam logic [63:0] Q30One = 64'd1073741824;
	localparam logic [63:0] HalfPiQ30 = 64'd1686629713;
	localparam logic [63:0] TaylorDiv [9] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
	};

	// Each entry holds the floored magnitude of 127*sin in the low bits and, in the
	// top bit, whether the ceiled magnitude is one larger.
	typedef logic [7:0] sine_lut_t [QuarterSteps];

	function automatic sine_lut_t build_sine_lut();
		sine_lut_t lut;
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic [63:0] a;
		logic [63:0] fl;
		logic [63:0] cl;
		lut[0] = 8'd0;
		for (int q = 1; q < QuarterSteps; q++) begin
			x = (HalfPiQ30 * 64'(4 * q)) / SineSteps;
			x2 = (x * x) >> 30;
			term = x;
			sum = x;
			for (int k = 1; k <= 9; k++) begin
				term = ((term * x2) >> 30) / TaylorDiv[k-1];
				if ((k % 2) == 1) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
			end
			a = 64'd127 * sum;
			fl = a >> 30;
			cl = (a + Q30One - 64'd1) >> 30;
			if (fl > 64'd127) begin
				fl = 64'd127;
			end
			if (cl > 64'd127) begin
				cl = 64'd127;
			end
			lut[q] = {(cl != fl), fl[6:0]};
		end
		return lut;
	endfunction

	localparam sine_lut_t SineLut = build_sine_lut();

endpackage

`default_nettype wire

@@ rtl/mwg_front.sv @@
`default_nettype none

module mwg_front #(
	parameter int POS_W = 10,
	parameter int PER_W = 11,
	parameter int NUM_W = 20
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        restart,
	input  wire logic [mwg_pkg::ModeW-1:0]   wave_mode,
	input  wire logic [PER_W-1:0]            period,
	output logic                             push_valid,
	input  wire logic                        push_ready,
	output mwg_pkg::mwg_ctrl_t               push_ctrl,
	output logic [NUM_W-1:0]                 push_num,
	output logic [PER_W-1:0]                 push_period
);
	import mwg_pkg::*;

	logic [POS_W-1:0] position_q;
	logic [POS_W-1:0] pos_raw;
	logic [POS_W-1:0] pos;
	logic [POS_W-1:0] tri_x;
	logic [PER_W-1:0] half;
	logic [PER_W-1:0] pos_ext;
	logic [PER_W-1:0] down;
	logic [PER_W-1:0] pos_inc;
	logic             lower;
	logic             accept;

	assign accept = in_valid && in_ready;
	assign in_ready = push_ready;
	assign push_valid = in_valid;
	assign push_period = period;

	assign pos_raw = restart ? '0 : position_q;
	assign pos = (PER_W'(pos_raw) >= period) ? '0 : pos_raw;
	assign pos_ext = PER_W'(pos);
	assign half = period >> 1;
	assign lower = pos_ext < half;
	assign down = period - pos_ext;
	assign tri_x = lower ? pos : POS_W'(down);
	assign pos_inc = pos_ext + PER_W'(1);

	always_comb begin
		push_ctrl.period_end = (pos_ext == (period - PER_W'(1)));
		push_ctrl.direct = lower ? FullCode : '0;
		push_ctrl.kind = OpLinear;
		push_num = '0;
		unique case (wave_mode)
			ModeSine: begin
				push_ctrl.kind = OpSine;
				push_num = {pos, {QuotW{1'b0}}};
			end
			ModeSquare: begin
				push_ctrl.kind = OpDirect;
			end
			ModeTriangle: begin
				push_num = NUM_W'({tri_x, 9'b0}) - NUM_W'({tri_x, 1'b0});
			end
			ModeSaw: begin
				push_num = NUM_W'({pos, 8'b0}) - NUM_W'(pos);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			position_q <= '0;
		end else if (accept) begin
			position_q <= (pos_inc >= period) ? '0 : POS_W'(pos_inc);
		end
	end

endmodule

`default_nettype wire

@@ rtl/mwg_queue.sv @@
`default_nettype none

module mwg_queue #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push_valid,
	output logic                  push_ready,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  pop_valid,
	input  wire logic             pop_ready,
	output logic [WIDTH-1:0]      pop_data
);
	import mwg_pkg::*;

	localparam int Depth = 2;

	logic [WIDTH-1:0] entry_q [Depth];
	logic             wr_ptr_q;
	logic             rd_ptr_q;
	logic [1:0]       count_q;
	logic             do_push;
	logic             do_pop;

	assign push_ready = (count_q != 2'(Depth));
	assign pop_valid = (count_q != 2'd0);
	assign pop_data = entry_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/mwg_back.sv @@
`default_nettype none

module mwg_back #(
	parameter int POS_W = 10,
	parameter int PER_W = 11,
	parameter int NUM_W = 20
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          pop_valid,
	output logic                               pop_ready,
	input  wire mwg_pkg::mwg_ctrl_t            pop_ctrl,
	input  wire logic [NUM_W-1:0]              pop_num,
	input  wire logic [PER_W-1:0]              pop_period,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [mwg_pkg::SampleW-1:0]        sample,
	output logic                               period_end
);
	import mwg_pkg::*;

	localparam logic [1:0] BkIdle = 2'd0;
	localparam logic [1:0] BkDiv = 2'd1;
	localparam logic [1:0] BkDone = 2'd2;
	localparam int CntW = $clog2(QuotW);

	logic [1:0]         state_q;
	op_t                kind_q;
	logic               pend_q;
	logic [SampleW-1:0] direct_q;
	logic [PER_W-1:0]   per_q;
	logic [PER_W-1:0]   rem_q;
	logic [QuotW-1:0]   low_q;
	logic [QuotW-1:0]   quot_q;
	logic [CntW-1:0]    cnt_q;
	logic               out_valid_q;
	logic [SampleW-1:0] sample_q;
	logic               period_end_q;

	logic [PER_W:0]     trial;
	logic               fits;
	logic               neg;
	logic [FoldW-1:0]   fold;
	logic [FoldW-1:0]   quad;
	logic [7:0]         lut_entry;
	logic [6:0]         mag;
	logic [SampleW-1:0] sine_val;
	logic [SampleW-1:0] result;
	logic               out_free;

	assign pop_ready = (state_q == BkIdle);
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign sample = sample_q;
	assign period_end = period_end_q;

	assign trial = {rem_q, low_q[QuotW-1]};
	assign fits = trial >= {1'b0, per_q};

	assign neg = quot_q[QuotW-1];
	assign fold = quot_q[FoldW-1:0];
	assign quad = (fold > FoldW'(QuarterSteps)) ? (FoldW'(HalfSteps) - fold) : fold;
	assign lut_entry = SineLut[quad[LutIdxW-1:0]];
	assign mag = neg ? (lut_entry[6:0] + 7'(lut_entry[7])) : lut_entry[6:0];

	always_comb begin
		if (quad == '0) begin
			sine_val = MidCode;
		end else if (quad == FoldW'(QuarterSteps)) begin
			sine_val = neg ? '0 : PeakCode;
		end else if (neg) begin
			sine_val = MidCode - SampleW'(mag);
		end else begin
			sine_val = MidCode + SampleW'(mag);
		end
	end

	always_comb begin
		unique case (kind_q)
			OpSine: result = sine_val;
			OpLinear: result = (quot_q > QuotW'(FullCode)) ? FullCode : quot_q[SampleW-1:0];
			default: result = direct_q;
		endcase
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BkIdle: begin
				kind_q <= pop_ctrl.kind;
				pend_q <= pop_ctrl.period_end;
				direct_q <= pop_ctrl.direct;
				per_q <= pop_period;
				rem_q <= PER_W'(pop_num[NUM_W-1:QuotW]);
				low_q <= pop_num[QuotW-1:0];
			end
			BkDiv: begin
				rem_q <= fits ? PER_W'(trial - {1'b0, per_q}) : PER_W'(trial);
				low_q <= low_q << 1;
				quot_q <= {quot_q[QuotW-2:0], fits};
			end
			default: begin
			end
		endcase
		if (state_q == BkDone && out_free) begin
			sample_q <= result;
			period_end_q <= pend_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BkIdle;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				BkIdle: begin
					cnt_q <= '0;
					if (pop_valid) begin
						state_q <= (pop_ctrl.kind == OpDirect) ? BkDone : BkDiv;
					end
				end
				BkDiv: begin
					cnt_q <= cnt_q + CntW'(1);
					if (cnt_q == CntW'(QuotW - 1)) begin
						state_q <= BkDone;
					end
				end
				BkDone: begin
					if (out_free) begin
						state_q <= BkIdle;
					end
				end
				default: begin
					state_q <= BkIdle;
				end
			endcase
			if (state_q == BkDone && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/multi_waveform_generator.sv @@
`default_nettype none

// Waveform generator: every input word is one sample tick and yields one output word
// holding an 8-bit DAC code for the selected waveform (sine, square, triangle or
// sawtooth) and a flag on the last position of each period. The front end keeps the
// position counter and takes one word per cycle while its two-entry queue has room.
// The back end serves one word at a time: square goes straight to the output register,
// while sine, triangle and sawtooth first pass through the 10-step radix-2 divider
// that scales the position by the period. The period is clamped to 2..PERIOD_MAX.
module multi_waveform_generator #(
	parameter int PERIOD_MAX = 1024
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic                           cfg_index,
	input  wire logic [mwg_pkg::PeriodRegW-1:0] cfg_data,
	input  wire logic                           in_valid,
	output logic                                in_ready,
	input  wire logic                           restart,
	output logic                                out_valid,
	input  wire logic                           out_ready,
	output logic [mwg_pkg::SampleW-1:0]         sample,
	output logic                                period_end
);
	import mwg_pkg::*;

	localparam int PosW = ($clog2(PERIOD_MAX) > PeriodRegW) ? PeriodRegW : $clog2(PERIOD_MAX);
	localparam int PerW = ($clog2(PERIOD_MAX + 1) > PeriodRegW) ?
		PeriodRegW : $clog2(PERIOD_MAX + 1);
	localparam int NumW = PosW + QuotW;
	localparam int CtrlW = $bits(mwg_ctrl_t);
	localparam int QueueW = CtrlW + NumW + PerW;

	logic [ModeW-1:0]       wave_mode_q;
	logic [PeriodRegW-1:0]  period_q;
	logic [PerW-1:0]        eff_period;

	logic                   push_valid;
	logic                   push_ready;
	mwg_ctrl_t              push_ctrl;
	logic [NumW-1:0]        push_num;
	logic [PerW-1:0]        push_period;
	logic                   q_pop_valid;
	logic                   q_pop_ready;
	logic [QueueW-1:0]      q_pop_data;
	mwg_ctrl_t              pop_ctrl;
	logic [NumW-1:0]        pop_num;
	logic [PerW-1:0]        pop_period;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q <= ModeSine;
			period_q <= 11'd100;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				RegWaveMode: wave_mode_q <= cfg_data[ModeW-1:0];
				RegPeriod: period_q <= cfg_data;
			endcase
		end
	end

	always_comb begin
		if (period_q < 11'd2) begin
			eff_period = PerW'(2);
		end else if (32'(period_q) > PERIOD_MAX) begin
			eff_period = PerW'(PERIOD_MAX);
		end else begin
			eff_period = PerW'(period_q);
		end
	end

	mwg_front #(
		.POS_W(PosW),
		.PER_W(PerW),
		.NUM_W(NumW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.wave_mode  (wave_mode_q),
		.period     (eff_period),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_ctrl  (push_ctrl),
		.push_num   (push_num),
		.push_period(push_period)
	);

	mwg_queue #(
		.WIDTH(QueueW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data ({push_ctrl, push_num, push_period}),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_data  (q_pop_data)
	);

	assign pop_ctrl = q_pop_data[QueueW-1 -: CtrlW];
	assign pop_num = q_pop_data[PerW +: NumW];
	assign pop_period = q_pop_data[PerW-1:0];

	mwg_back #(
		.POS_W(PosW),
		.PER_W(PerW),
		.NUM_W(NumW)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (q_pop_valid),
		.pop_ready (q_pop_ready),
		.pop_ctrl  (pop_ctrl),
		.pop_num   (pop_num),
		.pop_period(pop_period),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sample    (sample),
		.period_end(period_end)
	);

	// A full queue always has a word waiting for the back end.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> q_pop_valid)
		else $error("queue reports full while empty");

	// Once the back end takes a word it is busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(q_pop_valid && q_pop_ready) |=> !q_pop_ready)
		else $error("back end took two words in a row");

	// Only square waves skip the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |->
			((push_ctrl.kind == OpDirect) == (wave_mode_q == ModeSquare)))
		else $error("word classified against the selected waveform");

endmodule

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

	import mwg_pkg::*;

	localparam int PeriodMax = 1024;

	typedef struct packed {
		logic [SampleW-1:0] level;
		logic               period_end;
	} dac_word_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic                   cfg_index;
	logic [PeriodRegW-1:0]  cfg_data;
	logic                   in_valid;
	logic                   in_ready;
	logic                   restart;
	logic                   out_valid;
	logic                   out_ready;
	logic [SampleW-1:0]     sample;
	logic                   period_end;

	logic [ModeW-1:0]       model_mode;
	logic [PeriodRegW-1:0]  model_period;
	int unsigned            wave_pos;

	int                     send_idle_pct;
	int                     recv_idle_pct;
	int                     mismatch_count;
	int                     ticks_queued;
	bit                     word_in_taken;
	bit                     pending_ticks[$];
	dac_word_t              dac_expected[$];

	always #5 clk = ~clk;

	multi_waveform_generator #(
		.PERIOD_MAX(PeriodMax)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.restart(restart),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample(sample),
		.period_end(period_end)
	);

	// The sine is folded into the first quadrant and evaluated as a Q30 Taylor series.
	function automatic logic [SampleW-1:0] sine_level(int unsigned step);
		longint unsigned u;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned acc;
		longint unsigned mag;
		bit              neg;
		u = 4 * step;
		neg = 1'b0;
		if (u >= 2 * SineSteps) begin
			neg = 1'b1;
			u = u - 2 * SineSteps;
		end
		if (u > SineSteps) begin
			u = 2 * SineSteps - u;
		end
		if (u == 0) begin
			return MidCode;
		end
		if (u == SineSteps) begin
			mag = 127;
		end else begin
			x = (HalfPiQ30 * u) / SineSteps;
			x2 = (x * x) >> 30;
			term = x;
			acc = x;
			for (int j = 1; j <= 9; j++) begin
				term = ((term * x2) >> 30) / longint'(2 * j * (2 * j + 1));
				if (j % 2 == 1) begin
					acc = acc - term;
				end else begin
					acc = acc + term;
				end
			end
			mag = 127 * acc;
			mag = neg ? ((mag + Q30One - 1) >> 30) : (mag >> 30);
			if (mag > 127) begin
				mag = 127;
			end
		end
		return neg ? SampleW'(127 - mag) : SampleW'(127 + mag);
	endfunction

	function automatic dac_word_t next_dac_word(logic clear_pos);
		int unsigned     p;
		int unsigned     half;
		int unsigned     pos;
		longint unsigned v;
		dac_word_t       w;
		p = model_period;
		if (p < 2) begin
			p = 2;
		end
		if (p > PeriodMax) begin
			p = PeriodMax;
		end
		half = p / 2;
		if (clear_pos) begin
			wave_pos = 0;
		end
		if (wave_pos >= p) begin
			wave_pos = 0;
		end
		pos = wave_pos;
		case (model_mode)
			ModeSine: begin
				v = sine_level((pos * SineSteps) / p);
			end
			ModeSquare: begin
				v = (pos < half) ? FullCode : 0;
			end
			ModeTriangle: begin
				v = (pos < half) ? (510 * pos) / p : (510 * (p - pos)) / p;
				if (v > 255) begin
					v = 255;
				end
			end
			default: begin
				v = (255 * pos) / p;
			end
		endcase
		w.level = v[SampleW-1:0];
		w.period_end = (pos == p - 1);
		wave_pos = (pos + 1 >= p) ? 0 : pos + 1;
		return w;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("%0t: mismatch on %s: got %0d, want %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin
		dac_word_t want;
		word_in_taken = arst_n && in_valid && in_ready;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				dac_expected.push_back(next_dac_word(restart));
			end
			if (out_valid && out_ready) begin
				if (dac_expected.size() == 0) begin
					report_mismatch("word with nothing pending", sample, 0);
				end else begin
					want = dac_expected.pop_front();
					if (sample !== want.level) begin
						report_mismatch("sample", sample, want.level);
					end
					if (period_end !== want.period_end) begin
						report_mismatch("period_end", period_end, want.period_end);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			restart <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			if (!in_valid || word_in_taken) begin
				if (pending_ticks.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					restart <= pending_ticks.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || in_valid || dac_expected.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_reg(logic idx, logic [PeriodRegW-1:0] data);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx == RegWaveMode) begin
			model_mode = data[ModeW-1:0];
		end else begin
			model_period = data;
		end
	endtask

	// The upper bits of the mode write carry random data that the block must drop.
	task automatic set_tone(logic [ModeW-1:0] wave, logic [PeriodRegW-1:0] per);
		logic [PeriodRegW-1:0] d;
		wait_idle();
		d = PeriodRegW'($urandom);
		d[ModeW-1:0] = wave;
		write_reg(RegWaveMode, d);
		write_reg(RegPeriod, per);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic push_tick(bit clear_pos);
		pending_ticks.push_back(clear_pos);
		ticks_queued++;
	endtask

	task automatic queue_ticks(int count, int restart_pct);
		for (int i = 0; i < count; i++) begin
			push_tick($urandom_range(0, 99) < restart_pct);
		end
	endtask

	task automatic random_segment();
		logic [ModeW-1:0] wave;
		int unsigned      per;
		int unsigned      eff;
		int unsigned      r;
		int unsigned      n;
		wave = ModeW'($urandom_range(0, 3));
		r = $urandom_range(0, 99);
		if (r < 4) begin
			per = $urandom_range(0, 1);
		end else if (r < 9) begin
			per = $urandom_range(PeriodMax + 1, 2047);
		end else if (r < 15) begin
			per = $urandom_range(65, PeriodMax);
		end else begin
			per = $urandom_range(2, 64);
		end
		eff = (per < 2) ? 2 : ((per > PeriodMax) ? PeriodMax : per);
		n = (eff <= 64) ? $urandom_range(8, 3 * eff + 8) : $urandom_range(20, 150);
		set_tone(wave, per[PeriodRegW-1:0]);
		queue_ticks(n, 3);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = RegWaveMode;
		cfg_data = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		out_ready = 1'b0;
		model_mode = ModeSine;
		model_period = 100;
		wave_pos = 0;
		send_idle_pct = 31;
		recv_idle_pct = 73;
		mismatch_count = 0;
		ticks_queued = 0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		set_tone(ModeSine, 4);
		queue_ticks(5, 0);
		set_tone(ModeSquare, 0);
		queue_ticks(3, 0);
		set_tone(ModeSaw, 1);
		queue_ticks(2, 0);
		set_tone(ModeTriangle, 2047);
		queue_ticks(2, 0);
		// An odd period lets the first falling triangle value pass full scale.
		set_tone(ModeTriangle, 3);
		queue_ticks(4, 0);
		set_tone(ModeSaw, 100);
		push_tick(1'b0);
		push_tick(1'b0);
		push_tick(1'b0);
		push_tick(1'b1);
		push_tick(1'b0);
		push_tick(1'b0);
		// Shrinking the period leaves the position past its end.
		set_tone(ModeSaw, 2);
		queue_ticks(2, 0);

		while (ticks_queued < 450) begin
			random_segment();
		end

		wait_idle();
		send_idle_pct = 73;
		recv_idle_pct = 31;
		set_tone(ModeSine, PeriodMax);
		push_tick(1'b1);
		queue_ticks(PeriodMax + 5, 0);

		wait_idle();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		while (ticks_queued < 1950) begin
			random_segment();
		end

		wait_idle();
		repeat (40) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	initial begin
		#(5_000_000);
		$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ files.f @@
rtl/mwg_pkg.sv
rtl/mwg_front.sv
rtl/mwg_queue.sv
rtl/mwg_back.sv
rtl/multi_waveform_generator.sv
dv/tb_top.sv
